/* sv/ftrp_pkg.sv */
`timescale 1ns / 1ps

package ftrp_pkg;

   localparam int FTRP_NUM_STATES = 8;

   localparam int OP_W     = 3;
   localparam int TARGET_W = 3;
   localparam int CUR_W    = 3;
   localparam int MASK_W   = 8;
   localparam int REQ_W    = 8;
   localparam int RSP_W    = 16;

   typedef enum logic [OP_W-1:0] {
      OP_STEP       = 3'd0,
      OP_CHANGE     = 3'd1,
      OP_GARBAGE    = 3'd2,
      OP_DELETE_ONE = 3'd3,
      OP_DELETE_ALL = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_APPLY,
      ST_CLOSE,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      CL_IDLE,
      CL_ISSUE,
      CL_DATA
   } closure_state_type;

   typedef logic [2:0] edge_rom_type [8];

   localparam edge_rom_type RESET_EDGE0 = '{3'd0, 3'd5, 3'd4, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5};
   localparam edge_rom_type RESET_EDGE1 = '{3'd1, 3'd7, 3'd3, 3'd6, 3'd0, 3'd6, 3'd2, 3'd4};

endpackage

/* sv/fsm_table_reachability_pruner.sv */
`timescale 1ns / 1ps

// channel  ports        dir  beat contents
// req      req_t*       in   operation, edge_bit, target_state
// rsp      rsp_t*       out  cur_state, state_mask, deleted_flag
//
// after reset the table loads its initial graph one row at a time, req_tready low
// step and change go through read, apply and result; delete one and unused codes go to result
// garbage and delete all run the closure unit, which issues one table row read and takes
// its data for each of the R reached states, then go to result
// a result waits in the output register while rsp_tready is low; the next beat is taken
// meanwhile and holds its result until the register frees

module fsm_table_reachability_pruner
   import ftrp_pkg::*;
#(
   parameter int NUM_STATES = FTRP_NUM_STATES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // operation[2:0], edge_bit[3], target_state[6:4], 0
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // cur_state[2:0], state_mask[10:3],
                                        // deleted_flag[11], 0
);

   localparam int SW = $clog2(NUM_STATES);
   localparam int RW = 2 * SW;

   ctrl_state_type state_ff, state_in;

   logic [SW-1:0]         init_cnt_ff, init_cnt_in;
   logic [SW-1:0]         present_ff, present_in;
   logic [NUM_STATES-1:0] reached_ff, reached_in;
   logic [NUM_STATES-1:0] deleted_ff, deleted_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic                  bit_ff, bit_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic [MASK_W-1:0]     res_mask_ff, res_mask_in;
   logic                  res_flag_ff, res_flag_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [RW-1:0]         reset_rows [NUM_STATES];

   logic                  wr_en;
   logic [SW-1:0]         wr_addr;
   logic [RW-1:0]         wr_data;
   logic                  ctrl_rd_en;
   logic                  rd_en;
   logic [SW-1:0]         rd_addr;
   logic [RW-1:0]         rd_data;

   logic                  cl_start;
   logic                  cl_rd_en;
   logic [SW-1:0]         cl_rd_addr;
   logic                  cl_done;
   logic [NUM_STATES-1:0] cl_seen;

   logic                  accept;
   logic [OP_W-1:0]       req_op;
   logic                  req_bit;
   logic [TARGET_W-1:0]   req_target;
   logic [SW-1:0]         req_tidx;
   logic                  req_in_range;
   logic                  tgt_in_range;
   logic [NUM_STATES-1:0] unreached;
   logic [NUM_STATES-1:0] new_deleted;

   for (genvar g = 0; g < NUM_STATES; g++) begin : g_reset_row
      localparam int E0 = (g < 8) ? int'(RESET_EDGE0[g % 8]) % NUM_STATES : g;
      localparam int E1 = (g < 8) ? int'(RESET_EDGE1[g % 8]) % NUM_STATES : g;
      assign reset_rows[g] = {SW'(E1), SW'(E0)};
   end

   ftrp_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_STATES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ftrp_closure #(
      .NUM_STATES (NUM_STATES)
   ) u_closure (
      .clock   (clock),
      .reset   (reset),
      .start   (cl_start),
      .root    (present_ff),
      .rd_data (rd_data),
      .rd_en   (cl_rd_en),
      .rd_addr (cl_rd_addr),
      .done    (cl_done),
      .seen    (cl_seen)
   );

   assign rd_en   = cl_rd_en | ctrl_rd_en;
   assign rd_addr = cl_rd_en ? cl_rd_addr : present_ff;

   assign req_op       = req_tdata[2:0];
   assign req_bit      = req_tdata[3];
   assign req_target   = req_tdata[6:4];
   assign req_tidx     = SW'(req_target);
   assign req_in_range = int'(req_target) < NUM_STATES;
   assign tgt_in_range = int'(target_ff) < NUM_STATES;
   assign accept       = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         present_ff   <= '0;
         reached_ff   <= '0;
         deleted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         present_ff   <= present_in;
         reached_ff   <= reached_in;
         deleted_ff   <= deleted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bit_ff      <= bit_in;
      target_ff   <= target_in;
      res_mask_ff <= res_mask_in;
      res_flag_ff <= res_flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      present_in   = present_ff;
      reached_in   = reached_ff;
      deleted_in   = deleted_ff;
      op_in        = op_ff;
      bit_in       = bit_ff;
      target_in    = target_ff;
      res_mask_in  = res_mask_ff;
      res_flag_in  = res_flag_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = present_ff;
      wr_data      = rd_data;
      ctrl_rd_en   = 1'b0;
      cl_start     = 1'b0;
      unreached    = ~cl_seen;
      new_deleted  = unreached & ~deleted_ff;

      case (state_ff)
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = init_cnt_ff;
            wr_data     = reset_rows[init_cnt_ff];
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == SW'(NUM_STATES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               op_in       = req_op;
               bit_in      = req_bit;
               target_in   = req_target;
               res_mask_in = '0;
               res_flag_in = 1'b0;
               case (req_op)
                  OP_STEP, OP_CHANGE: begin
                     ctrl_rd_en = 1'b1;
                     state_in   = ST_APPLY;
                  end
                  OP_GARBAGE, OP_DELETE_ALL: begin
                     cl_start = 1'b1;
                     state_in = ST_CLOSE;
                  end
                  OP_DELETE_ONE: begin
                     if (req_in_range && !reached_ff[req_tidx] && !deleted_ff[req_tidx]) begin
                        deleted_in  = deleted_ff | (NUM_STATES'(1) << req_tidx);
                        res_flag_in = 1'b1;
                     end
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_APPLY: begin
            if (op_ff == OP_STEP) begin
               present_in = bit_ff ? rd_data[RW-1:SW] : rd_data[SW-1:0];
            end else begin
               wr_en   = tgt_in_range;
               wr_data = bit_ff ? {SW'(target_ff), rd_data[SW-1:0]}
                                : {rd_data[RW-1:SW], SW'(target_ff)};
            end
            state_in = ST_OUT;
         end
         ST_CLOSE: begin
            if (cl_done) begin
               reached_in = cl_seen;
               if (op_ff == OP_DELETE_ALL) begin
                  deleted_in  = deleted_ff | new_deleted;
                  res_mask_in = MASK_W'(new_deleted);
               end else begin
                  res_mask_in = MASK_W'(unreached);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, res_flag_ff, res_mask_ff, CUR_W'(present_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/ftrp_ram.sv */
`timescale 1ns / 1ps

module ftrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ftrp_closure.sv */
`timescale 1ns / 1ps

module ftrp_closure
   import ftrp_pkg::*;
#(
   parameter int NUM_STATES = FTRP_NUM_STATES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [$clog2(NUM_STATES)-1:0] root,
   input  logic [2*$clog2(NUM_STATES)-1:0] rd_data,
   output logic                          rd_en,
   output logic [$clog2(NUM_STATES)-1:0] rd_addr,
   output logic                          done,
   output logic [NUM_STATES-1:0]         seen
);

   localparam int SW = $clog2(NUM_STATES);

   closure_state_type state_ff, state_in;
   logic [NUM_STATES-1:0] seen_ff, seen_in;
   logic [NUM_STATES-1:0] expanded_ff, expanded_in;
   logic [NUM_STATES-1:0] pending;
   logic [SW-1:0]         pick;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      seen_ff     <= seen_in;
      expanded_ff <= expanded_in;
   end

   // lowest pending state
   always_comb begin
      pending = seen_ff & ~expanded_ff;
      pick    = '0;
      for (int i = NUM_STATES - 1; i >= 0; i--) begin
         if (pending[i]) begin
            pick = SW'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      expanded_in = expanded_ff;
      rd_en       = 1'b0;
      rd_addr     = pick;
      done        = 1'b0;
      case (state_ff)
         CL_IDLE: begin
            if (start) begin
               seen_in     = NUM_STATES'(1) << root;
               expanded_in = '0;
               state_in    = CL_ISSUE;
            end
         end
         CL_ISSUE: begin
            if (pending == '0) begin
               done     = 1'b1;
               state_in = CL_IDLE;
            end else begin
               rd_en       = 1'b1;
               expanded_in = expanded_ff | (NUM_STATES'(1) << pick);
               state_in    = CL_DATA;
            end
         end
         CL_DATA: begin
            seen_in  = seen_ff | (NUM_STATES'(1) << rd_data[SW-1:0])
                               | (NUM_STATES'(1) << rd_data[2*SW-1:SW]);
            state_in = CL_ISSUE;
         end
         default: begin
            state_in = CL_IDLE;
         end
      endcase
   end

   assign seen = seen_ff;

endmodule
